// ----- hdl/rotary_dial_pulse_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// Rotary dial pulse decoder assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ROTARY_DIAL_PULSE_DECODER_ASSERT_SVH
`define ROTARY_DIAL_PULSE_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define RDPD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("rdpd assertion failed");

`define RDPD_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("rdpd forbidden condition seen");

`else

`define RDPD_ASSERT(lbl, clk, rstn, prop)

`define RDPD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- hdl/rdpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotary dial pulse decoder package
// Payload types, command format and fixed codes shared by the decoder.
// ----------------------------------------------------------------------------
package rdpd_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_DIAL = 2'd1;
    localparam logic [1:0] OP_HOOK = 2'd2;

    localparam logic [1:0] MASK_NONE = 2'd0;
    localparam logic [1:0] MASK_RISE = 2'd1;
    localparam logic [1:0] MASK_FALL = 2'd2;
    localparam logic [1:0] MASK_BOTH = 2'd3;

    localparam logic [2:0] EV_HOOK     = 3'd0;
    localparam logic [2:0] EV_START    = 3'd1;
    localparam logic [2:0] EV_DIGIT    = 3'd2;
    localparam logic [2:0] EV_NUMDIGIT = 3'd3;
    localparam logic [2:0] EV_END      = 3'd4;

    localparam logic [2:0] CFG_ENABLE      = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE    = 3'd1;
    localparam logic [2:0] CFG_PULSE_GAP   = 3'd2;
    localparam logic [2:0] CFG_DIGIT_TMO   = 3'd3;
    localparam logic [2:0] CFG_END_TMO     = 3'd4;

    localparam logic [7:0]  DEF_DEBOUNCE  = 8'd20;
    localparam logic [11:0] DEF_PULSE_GAP = 12'd200;
    localparam logic [11:0] DEF_DIGIT_TMO = 12'd250;
    localparam logic [11:0] DEF_END_TMO   = 12'd2000;

    localparam logic [11:0] SINCE_MAX   = 12'hFFF;
    localparam logic [3:0]  PULSE_MAX   = 4'd15;
    localparam logic [3:0]  ZERO_PULSES = 4'd10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // wide enough for any store size up to 64 digits
    localparam int CMD_CNT_W = 7;
    localparam int CMD_IDX_W = 6;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] edge_mask;
    } t_in;

    typedef struct packed {
        logic [2:0] event_res;
        logic [5:0] value;
        logic [4:0] position;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_DIGIT,
        ACT_READOUT,
        ACT_END_ZERO
    } t_act;

    typedef struct packed {
        logic                 has_pre;
        logic [2:0]           pre_ev;
        logic                 pre_val;
        t_act                 act;
        logic [3:0]           digit;
        logic [CMD_IDX_W-1:0] idx;
        logic [CMD_CNT_W-1:0] count;
    } t_cmd;

endpackage

// ----- hdl/rdpd_front.sv -----
// ----------------------------------------------------------------------------
// Rotary dial pulse decoder front end
// Holds configuration and dial state, classifies each item into at most one command.
// ----------------------------------------------------------------------------
module rdpd_front import rdpd_pkg::*; #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  t_in                   i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_cmd_vld,
    output t_cmd                  o_cmd
);

    localparam int CW = $clog2(MAX_DIGITS + 1);

    logic          r_en,      n_en;
    logic [7:0]    r_deb,     n_deb;
    logic [11:0]   r_gap,     n_gap;
    logic [11:0]   r_dto,     n_dto;
    logic [11:0]   r_eto,     n_eto;
    logic [3:0]    r_pcnt,    n_pcnt;
    logic          r_pend,    n_pend;
    logic          r_started, n_started;
    logic          r_hook,    n_hook;
    logic [CW-1:0] r_dcnt,    n_dcnt;
    logic [11:0]   r_dtmr,    n_dtmr;
    logic [11:0]   r_etmr,    n_etmr;
    logic [11:0]   r_since,   n_since;

    t_cmd cmd;
    logic cmp;
    logic clr;
    logic hl;

    always_comb begin
        n_en      = r_en;
        n_deb     = r_deb;
        n_gap     = r_gap;
        n_dto     = r_dto;
        n_eto     = r_eto;
        n_pcnt    = r_pcnt;
        n_pend    = r_pend;
        n_started = r_started;
        n_hook    = r_hook;
        n_dcnt    = r_dcnt;
        n_dtmr    = r_dtmr;
        n_etmr    = r_etmr;
        n_since   = r_since;
        cmd       = '0;
        cmd.act   = ACT_NONE;
        cmp       = 1'b0;
        clr       = 1'b0;
        hl        = 1'b0;

        if (i_accept) begin
            case (i_in.opcode)
                OP_TICK: begin
                    if (r_since != SINCE_MAX) begin
                        n_since = r_since + 12'd1;
                    end
                    if (r_etmr != 12'd0) begin
                        n_etmr = r_etmr - 12'd1;
                        if (r_etmr == 12'd1) begin
                            cmd.act   = ACT_READOUT;
                            cmd.count = CMD_CNT_W'(r_dcnt);
                            clr       = 1'b1;
                        end
                    end else if (r_dtmr != 12'd0) begin
                        n_dtmr = r_dtmr - 12'd1;
                        if (r_dtmr == 12'd1) begin
                            cmp = 1'b1;
                        end
                    end
                end
                OP_DIAL, OP_HOOK: begin
                    if (i_in.edge_mask != MASK_BOTH && r_en) begin
                        n_since = 12'd0;
                        if (r_since >= {4'd0, r_deb}) begin
                            if (i_in.opcode == OP_HOOK) begin
                                hl          = (i_in.edge_mask == MASK_RISE);
                                n_hook      = hl;
                                cmd.has_pre = 1'b1;
                                cmd.pre_ev  = EV_HOOK;
                                cmd.pre_val = hl;
                                if (!hl && r_dcnt != '0) begin
                                    cmd.act = ACT_END_ZERO;
                                    clr     = 1'b1;
                                end
                            end else if (i_in.edge_mask == MASK_RISE) begin
                                if (!r_started) begin
                                    n_started   = 1'b1;
                                    cmd.has_pre = 1'b1;
                                    cmd.pre_ev  = EV_START;
                                end
                                n_dtmr = 12'd0;
                                n_etmr = 12'd0;
                                if (r_since >= r_gap && r_pend) begin
                                    cmp = 1'b1;
                                end
                            end else if (i_in.edge_mask == MASK_FALL && r_started) begin
                                if (!r_pend) begin
                                    n_pend = 1'b1;
                                    n_pcnt = 4'd0;
                                end else if (r_pcnt != PULSE_MAX) begin
                                    n_pcnt = r_pcnt + 4'd1;
                                end
                                n_etmr = 12'd0;
                                n_dtmr = (r_dto == 12'd0) ? 12'd1 : r_dto;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase

            if (cmp) begin
                if (r_dcnt == CW'(MAX_DIGITS)) begin
                    cmd.act   = ACT_READOUT;
                    cmd.count = CMD_CNT_W'(r_dcnt);
                    clr       = 1'b1;
                end else begin
                    cmd.act   = ACT_DIGIT;
                    cmd.digit = (r_pcnt >= ZERO_PULSES) ? 4'd0 : r_pcnt;
                    cmd.idx   = CMD_IDX_W'(r_dcnt);
                    n_dcnt    = r_dcnt + CW'(1);
                    n_pcnt    = 4'd0;
                    n_pend    = 1'b0;
                    n_dtmr    = 12'd0;
                    n_etmr    = (r_eto == 12'd0) ? 12'd1 : r_eto;
                end
            end
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE: begin
                    n_en = i_cfg_data[0];
                    if (!i_cfg_data[0]) begin
                        clr = 1'b1;
                    end
                end
                CFG_DEBOUNCE:  n_deb = i_cfg_data[7:0];
                CFG_PULSE_GAP: n_gap = i_cfg_data;
                CFG_DIGIT_TMO: n_dto = i_cfg_data;
                CFG_END_TMO:   n_eto = i_cfg_data;
                default: begin
                end
            endcase
        end

        if (clr) begin
            n_dcnt    = '0;
            n_pcnt    = 4'd0;
            n_pend    = 1'b0;
            n_started = 1'b0;
            n_dtmr    = 12'd0;
            n_etmr    = 12'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_deb     <= DEF_DEBOUNCE;
            r_gap     <= DEF_PULSE_GAP;
            r_dto     <= DEF_DIGIT_TMO;
            r_eto     <= DEF_END_TMO;
            r_pcnt    <= 4'd0;
            r_pend    <= 1'b0;
            r_started <= 1'b0;
            r_hook    <= 1'b0;
            r_dcnt    <= '0;
            r_dtmr    <= 12'd0;
            r_etmr    <= 12'd0;
            r_since   <= SINCE_MAX;
        end else begin
            r_en      <= n_en;
            r_deb     <= n_deb;
            r_gap     <= n_gap;
            r_dto     <= n_dto;
            r_eto     <= n_eto;
            r_pcnt    <= n_pcnt;
            r_pend    <= n_pend;
            r_started <= n_started;
            r_hook    <= n_hook;
            r_dcnt    <= n_dcnt;
            r_dtmr    <= n_dtmr;
            r_etmr    <= n_etmr;
            r_since   <= n_since;
        end
    end

    assign o_cmd_vld = i_accept && (cmd.has_pre || cmd.act != ACT_NONE);
    assign o_cmd     = cmd;

endmodule

// ----- hdl/rdpd_fifo.sv -----
// ----------------------------------------------------------------------------
// Rotary dial pulse decoder command queue
// Four-entry queue between the front end and the result sequencer.
// ----------------------------------------------------------------------------
module rdpd_fifo import rdpd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW:0]   r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + AW'(1) : r_wr;
        n_rd  = do_pop ? r_rd + AW'(1) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + (AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hdl/rdpd_back.sv -----
// ----------------------------------------------------------------------------
// Rotary dial pulse decoder result sequencer
// Executes queued commands, owns the digit store and the result register.
// ----------------------------------------------------------------------------
`include "rotary_dial_pulse_decoder_assert.svh"

module rdpd_back import rdpd_pkg::*; #(
    parameter int MAX_DIGITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_empty,
    input  t_cmd i_q_data,
    output logic o_q_pop,
    output logic o_empty,
    input  logic i_pop,
    output t_out o_out
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_ACT,
        S_RDOUT,
        S_END
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd,   n_cmd;
    logic [CW-1:0] r_idx,   n_idx;
    t_out          r_out,   n_out;
    logic          r_out_vld, n_out_vld;

    logic [3:0]    r_mem [MAX_DIGITS];
    logic [3:0]    r_rdata;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic          slot;

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_idx     = r_idx;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_pop;
        slot      = !r_out_vld || i_pop;
        o_q_pop   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_idx[IW-1:0];
        wr_en     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_data;
                    n_state = i_q_data.has_pre ? S_PRE : S_ACT;
                end
            end
            S_PRE: begin
                if (slot) begin
                    n_out_vld       = 1'b1;
                    n_out.event_res = r_cmd.pre_ev;
                    n_out.value     = 6'(r_cmd.pre_val);
                    n_out.position  = 5'd0;
                    n_out.last      = (r_cmd.act == ACT_NONE);
                    n_state         = (r_cmd.act == ACT_NONE) ? S_IDLE : S_ACT;
                end
            end
            S_ACT: begin
                case (r_cmd.act)
                    ACT_DIGIT: begin
                        if (slot) begin
                            n_out_vld       = 1'b1;
                            n_out.event_res = EV_DIGIT;
                            n_out.value     = 6'(r_cmd.digit);
                            n_out.position  = 5'd0;
                            n_out.last      = 1'b1;
                            wr_en           = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end
                    ACT_END_ZERO: begin
                        if (slot) begin
                            n_out_vld       = 1'b1;
                            n_out.event_res = EV_END;
                            n_out.value     = 6'd0;
                            n_out.position  = 5'd0;
                            n_out.last      = 1'b1;
                            n_state         = S_IDLE;
                        end
                    end
                    ACT_READOUT: begin
                        n_idx = '0;
                        if (r_cmd.count == '0) begin
                            n_state = S_END;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_state = S_RDOUT;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RDOUT: begin
                if (slot) begin
                    n_out_vld       = 1'b1;
                    n_out.event_res = EV_NUMDIGIT;
                    n_out.value     = 6'(r_rdata);
                    n_out.position  = 5'(r_idx);
                    n_out.last      = 1'b0;
                    if (CMD_CNT_W'(r_idx) + CMD_CNT_W'(1) < r_cmd.count) begin
                        n_idx   = r_idx + CW'(1);
                        rd_en   = 1'b1;
                        rd_addr = n_idx[IW-1:0];
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_END: begin
                if (slot) begin
                    n_out_vld       = 1'b1;
                    n_out.event_res = EV_END;
                    n_out.value     = r_cmd.count[5:0];
                    n_out.position  = 5'd0;
                    n_out.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_cmd.idx[IW-1:0]] <= r_cmd.digit;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_empty = !r_out_vld;
    assign o_out   = r_out;

    `RDPD_ASSERT(a_rdout_in_range, i_clk, i_rst_n, (r_state == S_RDOUT) |-> (CMD_CNT_W'(r_idx) < r_cmd.count))
    `RDPD_ASSERT(a_end_is_last, i_clk, i_rst_n, (r_out_vld && r_out.event_res == EV_END) |-> r_out.last)
    `RDPD_ASSERT_NEVER(a_numdigit_not_last, i_clk, i_rst_n, r_out_vld && r_out.event_res == EV_NUMDIGIT && r_out.last)
    `RDPD_ASSERT_NEVER(a_pop_only_idle, i_clk, i_rst_n, o_q_pop && (r_state != S_IDLE || i_q_empty))

endmodule

// ----- hdl/rotary_dial_pulse_decoder.sv -----
// ----------------------------------------------------------------------------
// Rotary dial pulse decoder
// Decodes dial pulses and hook edges into digits and dialed numbers.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive i_in with push high; an item is taken on a clock edge
//   where push is high and full is low. Items are 1 ms ticks, dial contact
//   edges and hook switch edges.
//   Result queue: while empty is low, o_out holds the oldest result; pop on
//   a clock edge with empty low takes it.
//   Config: write register i_cfg_index with i_cfg_data when i_cfg_valid is
//   high; o_cfg_ready is always high. Write only while the block is idle.
//   Path: a result passes through the command queue, the sequencer's
//   command register and the result register. A readout of N stored
//   digits yields N + 1 results at one per cycle while pop keeps the
//   result register free, paced by the digit store read port.
//   A four-entry command queue separates the front end from the sequencer,
//   so items keep being taken while results wait; full rises when that
//   queue fills, either because the receiver holds pop low or while a long
//   readout keeps the sequencer busy.
//   Reset clears all dial state and loads the default timing registers; the
//   decoder starts disabled.
// ----------------------------------------------------------------------------
module rotary_dial_pulse_decoder import rdpd_pkg::*; #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in                   i_in,
    output logic                  empty,
    input  logic                  pop,
    output t_out                  o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic accept;
    logic cmd_vld;
    t_cmd cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_cmd q_data;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    rdpd_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_vld   (cmd_vld),
        .o_cmd       (cmd)
    );

    rdpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_vld),
        .i_data  (cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    rdpd_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotary dial pulse decoder testbench
// Feeds ticks, dial contact edges and hook edges through the input queue,
// predicts every event the decoder reports, and compares each popped result
// field by field. Covers disabled operation, debounce, pulse counting, digit
// completion by timeout and by gap, number readout, hang-up, a full digit
// store under a long result stall, and random timing settings.
// ----------------------------------------------------------------------------
module tb import rdpd_pkg::*; ();

    localparam int MAX_DIGITS      = 32;
    localparam int TOTAL_ITEMS     = 430;
    localparam int DRAIN_CYCLES    = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT      = 4000;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    t_in                   i_in        = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // decoder image
    bit        m_enable;
    bit [7:0]  m_debounce;
    bit [11:0] m_pulse_gap;
    bit [11:0] m_digit_tmo;
    bit [11:0] m_end_tmo;
    bit [3:0]  m_pulses;
    bit        m_pending;
    bit        m_started;
    bit        m_hook;
    int        m_digits;
    bit [3:0]  m_store [MAX_DIGITS];
    bit [11:0] m_digit_timer;
    bit [11:0] m_end_timer;
    bit [11:0] m_since_edge;

    t_out dial_events [$];
    int   n_errors      = 0;
    int   n_items       = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   stall_left    = 0;
    int   idle_cycles   = 0;
    bit   tx_calm       = 1'b0;
    bit   rx_calm       = 1'b0;

    rotary_dial_pulse_decoder #(
        .MAX_DIGITS(MAX_DIGITS)
    ) u_top (
        .i_clk,
        .i_rst_n,
        .push,
        .full,
        .i_in,
        .empty,
        .pop,
        .o_out,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_index,
        .i_cfg_data
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit [11:0] timer_load(bit [11:0] t);
        return (t == 12'd0) ? 12'd1 : t;
    endfunction

    function automatic void note_event(logic [2:0] ev, int val, int pos);
        t_out r;
        r.event_res = ev;
        r.value     = val[5:0];
        r.position  = pos[4:0];
        r.last      = 1'b0;
        dial_events.push_back(r);
    endfunction

    function automatic void clear_number();
        m_digits      = 0;
        m_pulses      = 4'd0;
        m_pending     = 1'b0;
        m_started     = 1'b0;
        m_digit_timer = 12'd0;
        m_end_timer   = 12'd0;
    endfunction

    function automatic void reset_dial_model();
        m_enable    = 1'b0;
        m_debounce  = DEF_DEBOUNCE;
        m_pulse_gap = DEF_PULSE_GAP;
        m_digit_tmo = DEF_DIGIT_TMO;
        m_end_tmo   = DEF_END_TMO;
        clear_number();
        m_hook       = 1'b0;
        m_since_edge = SINCE_MAX;
        foreach (m_store[i]) m_store[i] = 4'd0;
    endfunction

    function automatic void read_out_number();
        for (int i = 0; i < m_digits; i++) note_event(EV_NUMDIGIT, int'(m_store[i]), i);
        note_event(EV_END, m_digits, 0);
        clear_number();
    endfunction

    function automatic void complete_digit();
        bit [3:0] d;
        d = (m_pulses >= ZERO_PULSES) ? 4'd0 : m_pulses;
        if (m_digits >= MAX_DIGITS) begin
            read_out_number();
        end else begin
            note_event(EV_DIGIT, int'(d), 0);
            m_store[m_digits] = d;
            m_digits++;
            m_pulses      = 4'd0;
            m_pending     = 1'b0;
            m_digit_timer = 12'd0;
            m_end_timer   = timer_load(m_end_tmo);
        end
    endfunction

    function automatic void predict_dial_events(t_in it);
        int        first_new;
        bit [11:0] age;
        t_out      tail;
        first_new = dial_events.size();
        if (it.opcode == OP_TICK) begin
            if (m_since_edge < SINCE_MAX) m_since_edge++;
            if (m_end_timer != 12'd0) begin
                m_end_timer--;
                if (m_end_timer == 12'd0) read_out_number();
            end
            if (m_digit_timer != 12'd0) begin
                m_digit_timer--;
                if (m_digit_timer == 12'd0) complete_digit();
            end
        end else if ((it.opcode == OP_DIAL || it.opcode == OP_HOOK) &&
                     it.edge_mask != MASK_BOTH && m_enable) begin
            age          = m_since_edge;
            m_since_edge = 12'd0;
            if (age >= m_debounce) begin
                if (it.opcode == OP_HOOK) begin
                    m_hook = (it.edge_mask == MASK_RISE);
                    note_event(EV_HOOK, int'(m_hook), 0);
                    if (!m_hook && m_digits != 0) begin
                        clear_number();
                        note_event(EV_END, 0, 0);
                    end
                end else if (it.edge_mask == MASK_RISE) begin
                    if (!m_started) begin
                        m_started = 1'b1;
                        note_event(EV_START, 0, 0);
                    end
                    m_digit_timer = 12'd0;
                    m_end_timer   = 12'd0;
                    if (age >= m_pulse_gap && m_pending) complete_digit();
                end else if (it.edge_mask == MASK_FALL && m_started) begin
                    if (!m_pending) begin
                        m_pending = 1'b1;
                        m_pulses  = 4'd0;
                    end else if (m_pulses < PULSE_MAX) begin
                        m_pulses++;
                    end
                    m_end_timer   = 12'd0;
                    m_digit_timer = timer_load(m_digit_tmo);
                end
            end
        end
        if (dial_events.size() > first_new) begin
            tail      = dial_events.pop_back();
            tail.last = 1'b1;
            dial_events.push_back(tail);
        end
    endfunction

    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_ENABLE: begin
                m_enable = data[0];
                if (!m_enable) clear_number();
            end
            CFG_DEBOUNCE:  m_debounce  = data[7:0];
            CFG_PULSE_GAP: m_pulse_gap = data;
            CFG_DIGIT_TMO: m_digit_tmo = data;
            CFG_END_TMO:   m_end_tmo   = data;
            default: ;
        endcase
    endfunction

    function automatic void report_mismatch(string fname, logic [7:0] want, logic [7:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        n_errors++;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(logic [1:0] op, logic [1:0] mask);
        t_in it;
        int  gap;
        it.opcode    = op;
        it.edge_mask = mask;
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        predict_dial_events(it);
        n_items++;
        gap = pick_gap(tx_calm);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(OP_TICK, 2'($urandom_range(0, 3)));
    endtask

    task automatic send_noise(int n);
        repeat (n) begin
            if ($urandom_range(0, 9) < 4) send_ticks(1);
            else send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (dial_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_config(bit en, int deb, int gap, int dto, int eto);
        logic [CFG_IDX_W-1:0]  reg_idx [5];
        logic [CFG_DATA_W-1:0] reg_val [5];
        reg_idx = '{CFG_ENABLE, CFG_DEBOUNCE, CFG_PULSE_GAP, CFG_DIGIT_TMO, CFG_END_TMO};
        reg_val = '{12'(en), 12'(deb), 12'(gap), 12'(dto), 12'(eto)};
        wait_idle();
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_idx[i];
            i_cfg_data  <= reg_val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            apply_reg_write(reg_idx[i], reg_val[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic dial_number(int span);
        int n_dig;
        int n_pulse;
        tx_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) send_item(OP_HOOK, MASK_RISE);
        n_dig = $urandom_range(1, 3);
        repeat (n_dig) begin
            send_item(OP_DIAL, MASK_RISE);
            send_ticks($urandom_range(0, span));
            n_pulse = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 17)
                                                  : $urandom_range(1, 4);
            for (int p = 0; p < n_pulse; p++) begin
                if (p != 0) begin
                    send_item(OP_DIAL, MASK_RISE);
                    send_ticks($urandom_range(0, span / 2));
                end
                send_item(OP_DIAL, MASK_FALL);
                send_ticks($urandom_range(0, span / 2));
            end
            send_ticks($urandom_range(0, span));
        end
        case ($urandom_range(0, 3))
            0: send_ticks($urandom_range(span, 2 * span + 4));
            1: send_item(OP_HOOK, ($urandom_range(0, 1) != 0) ? MASK_FALL : MASK_NONE);
            2: send_noise($urandom_range(1, 4));
            default: ;
        endcase
    endtask

    task automatic test_disabled_after_reset();
        send_item(OP_HOOK, MASK_RISE);
        send_item(OP_DIAL, MASK_RISE);
        send_item(OP_DIAL, MASK_FALL);
        send_item(OP_TICK, MASK_NONE);
        send_item(OP_HOOK, MASK_FALL);
    endtask

    task automatic test_directed_events();
        load_config(1'b1, 0, 3, 5, 4);
        send_item(OP_HOOK, MASK_RISE);
        send_item(OP_HOOK, MASK_NONE);
        send_item(OP_UNUSED, MASK_RISE);
        send_item(OP_DIAL, MASK_BOTH);
        send_item(OP_DIAL, MASK_NONE);
        send_item(OP_DIAL, MASK_FALL);
        send_item(OP_DIAL, MASK_RISE);
        send_item(OP_DIAL, MASK_FALL);
        repeat (3) send_item(OP_TICK, MASK_NONE);
        send_item(OP_DIAL, MASK_RISE);
        send_item(OP_DIAL, MASK_FALL);
        send_item(OP_DIAL, MASK_RISE);
        send_item(OP_DIAL, MASK_FALL);
        send_item(OP_DIAL, MASK_FALL);
        repeat (9) send_item(OP_TICK, MASK_NONE);
    endtask

    task automatic test_full_store_with_stall();
        load_config(1'b1, 0, 4095, 1, 4095);
        tx_calm = 1'b1;
        hold_requests++;
        send_item(OP_DIAL, MASK_RISE);
        repeat (MAX_DIGITS + 1) begin
            repeat ($urandom_range(1, 3)) send_item(OP_DIAL, MASK_FALL);
            send_item(OP_TICK, MASK_NONE);
        end
    endtask

    task automatic test_random_dialing();
        int goal;
        load_config(1'b1, 0, 0, 0, 0);
        goal = n_items + 50;
        while (n_items < goal) dial_number(4);

        load_config(1'b1, 255, 4095, 4095, 4095);
        send_noise(20);

        // leave a digit stored so that disabling has something to clear
        load_config(1'b1, 0, 5, 2, 4095);
        send_item(OP_DIAL, MASK_RISE);
        send_item(OP_DIAL, MASK_FALL);
        send_ticks(2);
        load_config(1'b0, $urandom_range(0, 3), $urandom_range(2, 10),
                    $urandom_range(1, 8), $urandom_range(1, 15));
        send_noise(15);
        load_config(1'b1, 0, 5, 2, 6);
        send_ticks(8);

        while (n_items < TOTAL_ITEMS) begin
            load_config(1'b1, $urandom_range(0, 3), $urandom_range(2, 10),
                        $urandom_range(1, 8), $urandom_range(1, 15));
            goal = n_items + 60;
            while (n_items < goal) dial_number(8);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            stall_left  = HOLD_OFF_CYCLES;
            pop <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            pop <= 1'b0;
        end else begin
            if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
            if (rx_calm || $urandom_range(0, 99) < 65) begin
                pop <= 1'b1;
            end else begin
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 40);
                pop <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && pop && !empty) begin
            if (dial_events.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                         $time, o_out.event_res, o_out.value, o_out.position, o_out.last);
                n_errors++;
            end else begin
                want = dial_events.pop_front();
                if (o_out.event_res !== want.event_res)
                    report_mismatch("event_res", 8'(want.event_res), 8'(o_out.event_res));
                if (o_out.value !== want.value)
                    report_mismatch("value", 8'(want.value), 8'(o_out.value));
                if (o_out.position !== want.position)
                    report_mismatch("position", 8'(want.position), 8'(o_out.position));
                if (o_out.last !== want.last)
                    report_mismatch("last", 8'(want.last), 8'(o_out.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        reset_dial_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_disabled_after_reset();
        test_directed_events();
        test_full_store_with_stall();
        test_random_dialing();
        wait_idle();
        if (dial_events.size() != 0) n_errors++;
        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/rdpd_pkg.sv
hdl/rdpd_front.sv
hdl/rdpd_fifo.sv
hdl/rdpd_back.sv
hdl/rotary_dial_pulse_decoder.sv
bench/tb.sv
